@@ design/tss_pkg.sv @@
// Package for the tone sweep sequencer: command codes, controller states,
// control/status structs and fixed constants. No dependencies.
`default_nettype none

package tss_pkg;

    // Command codes carried on s_tuser.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PLAY  = 2'd1;
    localparam logic [1:0] CMD_QUEUE = 2'd2;

    localparam int MCLK_W  = 28;
    localparam int FREQ_W  = 16;
    localparam int TICKS_W = 14;
    localparam int DVS_W   = 26;
    localparam int CNT_W   = 5;

    localparam logic [FREQ_W-1:0] FREQ_RESET   = 16'd1000;
    localparam logic [15:0]       PERIOD_RESET = 16'd80;
    localparam logic [15:0]       PERIOD_MAX   = 16'hFFFF;
    localparam logic [15:0]       PERIOD_MIN   = 16'd2;
    localparam logic [MCLK_W-1:0] MCLK_RESET   = 28'd64000000;
    localparam logic [DVS_W-1:0]  SCALE_HZ     = 26'd800;

    // ceil(t/5) = ((t + 4) * 52429) >> 18, exact for all 17-bit sums.
    localparam logic [16:0] ROUND_UP     = 17'd4;
    localparam logic [15:0] DIV5_RECIP   = 16'd52429;
    localparam int          DIV5_SHIFT   = 18;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic step_en;
        logic div_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ design/tss_divider.sv @@
// Restoring divider for the sample-timer period: master_clock / (800 * freq).
// One quotient bit per cycle. Depends on tss_pkg.
`default_nettype none

module tss_divider
    import tss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MCLK_W-1:0] dividend,
    input  wire logic [FREQ_W-1:0] freq,
    output logic                   done,
    output logic [MCLK_W-1:0]      quotient
);

    logic [DVS_W:0]    rem_reg, rem_next;
    logic [MCLK_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W+1:0]  diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DVS_W-1:0], quot_reg[MCLK_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = DVS_W'({{(DVS_W-FREQ_W){1'b0}}, freq} * SCALE_HZ);
            cnt_next  = CNT_W'(MCLK_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // A zero divisor leaves every trial positive, so the quotient saturates.
            if (!diff[DVS_W+1])
            begin
                rem_next  = diff[DVS_W:0];
                quot_next = {quot_reg[MCLK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                quot_next = {quot_reg[MCLK_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

endmodule

`default_nettype wire

@@ design/tss_datapath.sv @@
// Datapath of the tone sweep sequencer: tone slot, sweep, period register,
// output register and the period divider. Depends on tss_pkg, tss_divider.
`default_nettype none

module tss_datapath
    import tss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_cmd_t         cmd,
    output ctrl_status_t           status,
    input  wire logic [1:0]        in_cmd,
    input  wire logic [FREQ_W-1:0] in_freq,
    input  wire logic [15:0]       in_time_ms,
    input  wire logic [15:0]       in_step,
    input  wire logic              in_busy,
    input  wire logic              cfg_we,
    input  wire logic [MCLK_W-1:0] cfg_wdata,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [15:0]            out_period,
    output logic [14:0]            out_half,
    output logic                   out_tone_on,
    output logic                   out_taken
);

    logic [MCLK_W-1:0]  mclk_reg;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [15:0]        ptime_reg, ptime_next;
    logic [FREQ_W-1:0]  pfreq_reg, pfreq_next;
    logic [15:0]        pstep_reg, pstep_next;
    logic [FREQ_W-1:0]  cfreq_reg, cfreq_next;
    logic [15:0]        cstep_reg, cstep_next;
    logic               en_reg, en_next;
    logic               taken_reg, taken_next;
    logic               need_div_reg, need_div_next;
    logic [15:0]        period_reg, period_next;
    logic               out_valid_reg;
    logic [15:0]        out_period_reg;
    logic               out_tone_on_reg, out_taken_reg;
    logic [TICKS_W-1:0] ticks_dec;
    logic [16:0]        round_sum;
    logic [32:0]        recip_prod;
    logic [TICKS_W-1:0] ticks_reload;
    logic               div_done;
    logic [MCLK_W-1:0]  div_quot;

    tss_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mclk_reg),
        .freq     (cfreq_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        round_sum    = {1'b0, ptime_reg} + ROUND_UP;
        recip_prod   = {16'd0, round_sum} * {17'd0, DIV5_RECIP};
        ticks_reload = recip_prod[DIV5_SHIFT +: TICKS_W];
        ticks_dec    = (ticks_reg != '0) ? ticks_reg - 1'b1 : ticks_reg;

        ticks_next    = ticks_reg;
        ptime_next    = ptime_reg;
        pfreq_next    = pfreq_reg;
        pstep_next    = pstep_reg;
        cfreq_next    = cfreq_reg;
        cstep_next    = cstep_reg;
        en_next       = en_reg;
        taken_next    = 1'b0;
        need_div_next = 1'b0;

        unique case (in_cmd)
            CMD_PLAY:
            begin
                pstep_next = '0;
                pfreq_next = in_freq;
                ptime_next = in_time_ms;
                taken_next = 1'b1;
            end
            CMD_QUEUE:
            begin
                if (ptime_reg == '0)
                begin
                    pfreq_next = in_freq;
                    pstep_next = in_step;
                    ptime_next = in_time_ms;
                    taken_next = 1'b1;
                end
            end
            CMD_TICK:
            begin
                ticks_next = ticks_dec;
                if (ticks_dec == '0)
                begin
                    priority if (in_busy)
                    begin
                        ptime_next = '0;
                    end
                    else if (ptime_reg != '0)
                    begin
                        ticks_next = ticks_reload;
                        if (pfreq_reg != '0)
                        begin
                            cfreq_next    = pfreq_reg;
                            cstep_next    = pstep_reg;
                            en_next       = 1'b1;
                            need_div_next = 1'b1;
                        end
                        else
                        begin
                            en_next = 1'b0;
                        end
                        ptime_next = '0;
                    end
                    else
                    begin
                        en_next = 1'b0;
                    end
                end
                else if (!ticks_dec[0])
                begin
                    // Sweep every second tick; a frequency that wrapped to zero stays put.
                    if (cfreq_reg != '0 && cstep_reg != '0)
                    begin
                        cfreq_next    = cfreq_reg + cstep_reg;
                        need_div_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        period_next = period_reg;
        if (div_done)
        begin
            priority if (cfreq_reg == '0 || div_quot[MCLK_W-1:16] != '0)
                period_next = PERIOD_MAX;
            else if (div_quot[15:0] < PERIOD_MIN)
                period_next = PERIOD_MIN;
            else
                period_next = div_quot[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mclk_reg     <= MCLK_RESET;
            ticks_reg    <= '0;
            ptime_reg    <= '0;
            pfreq_reg    <= '0;
            pstep_reg    <= '0;
            cfreq_reg    <= FREQ_RESET;
            cstep_reg    <= '0;
            en_reg       <= 1'b0;
            taken_reg    <= 1'b0;
            need_div_reg <= 1'b0;
            period_reg   <= PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mclk_reg <= cfg_wdata;
            if (cmd.step_en)
            begin
                ticks_reg    <= ticks_next;
                ptime_reg    <= ptime_next;
                pfreq_reg    <= pfreq_next;
                pstep_reg    <= pstep_next;
                cfreq_reg    <= cfreq_next;
                cstep_reg    <= cstep_next;
                en_reg       <= en_next;
                taken_reg    <= taken_next;
                need_div_reg <= need_div_next;
            end
            period_reg <= period_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_period_reg  <= period_reg;
            out_tone_on_reg <= en_reg;
            out_taken_reg   <= taken_reg;
        end
    end

    assign status.need_div = need_div_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_period  = out_period_reg;
    assign out_half    = out_period_reg[15:1];
    assign out_tone_on = out_tone_on_reg;
    assign out_taken   = out_taken_reg;

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> period_reg >= PERIOD_MIN)
        else $error("period update fell below the minimum");

endmodule

`default_nettype wire

@@ design/tss_ctrl.sv @@
// Controller of the tone sweep sequencer: sequences state update, period
// division and result hand-off. Depends on tss_pkg.
`default_nettype none

module tss_ctrl
    import tss_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output ctrl_cmd_t         cmd,
    input  wire ctrl_status_t status
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.step_en = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_step_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_en |=> state_reg == ST_LOAD)
        else $error("accepted item did not move to the load state");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an item not yet taken");

endmodule

`default_nettype wire

@@ design/tone_sweep_sequencer_unit.sv @@
// Tone sweep sequencer: one result item per input item. When the period is recomputed
// (restoring divider, one quotient bit per cycle) the item passes the load, divide and emit
// states before the result is loaded into the output register; otherwise load and emit.
// One item is in work at a time; the next is taken while a result waits at the output.
// Asynchronous active-low reset: frequency 1000 Hz, period 80, tone off,
// master_clock 64000000, slot empty. Depends on tss_pkg, tss_ctrl, tss_datapath.
`default_nettype none

module tone_sweep_sequencer_unit
    import tss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tone_freq[15:0], tone_time_ms[31:16], sweep_step[47:32], voice_busy[48], zero pad
    input  wire logic [55:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // period_count[15:0], half_period[30:16], tone_on[31], request_taken[32], zero pad
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [27:0] cfg_wdata
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic [15:0]  out_period;
    logic [14:0]  out_half;
    logic         out_tone_on;
    logic         out_taken;

    tss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tss_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_cmd      (s_tuser),
        .in_freq     (s_tdata[15:0]),
        .in_time_ms  (s_tdata[31:16]),
        .in_step     (s_tdata[47:32]),
        .in_busy     (s_tdata[48]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_period  (out_period),
        .out_half    (out_half),
        .out_tone_on (out_tone_on),
        .out_taken   (out_taken)
    );

    assign m_tdata = {7'd0, out_taken, out_tone_on, out_half, out_period};

endmodule

`default_nettype wire
